FILE: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Field and register widths.
    localparam int ADDR_W     = 32;
    localparam int BSIZE_W    = 17;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Span of the pool: block size times block count.
    localparam int SPAN_W     = BSIZE_W + COUNT_W;
    // A valid offset lies below the largest span and fits in this width.
    localparam int OFF_W      = SPAN_W - 1;
    // One quotient bit is produced per divider step.
    localparam int DIV_STEPS  = COUNT_W;
    localparam int STEP_W     = 4;

    localparam int DEFAULT_MAX_BLOCKS = 1024;

    localparam logic [BSIZE_W-1:0] BSIZE_MIN   = 17'd8;
    localparam logic [BSIZE_W-1:0] BSIZE_MAX   = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Request codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_BSIZE = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_ALLOC,
        FSM_CHECK,
        FSM_DIVIDE,
        FSM_COMMIT,
        FSM_FINISH
    } fsm_state_t;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Allocates and releases equal-sized blocks of a pool held as a LIFO free list.
//
// Requests arrive on the s_ channel (s_cmd, s_address) with valid/ready and
// each one produces exactly one result transaction on the m_ channel
// (m_block_address, m_status, m_used_count). One request is worked at a time.
// An accepted allocation passes through ALLOC, where popping the free list
// needs one read of the link memory and the address needs a registered
// multiply, and then FINISH. For a release the block index is found by
// an 11-step shift-and-subtract divider, one quotient bit per cycle, and a
// release off a block boundary is only rejected after that divider. A full
// pool goes straight to FINISH; a release outside the pool or with nothing
// allocated is rejected in CHECK and then goes to FINISH. s_ready returns in
// the same cycle that the result is loaded into the output register.
// The result sits in an output register; while the receiver stalls the block
// finishes the current request and waits with s_ready low until that register
// frees. Reset (aresetn low, synchronous) empties the pool and restores the
// default registers; the link memory needs no clearing because blocks never
// handed out are served from a fresh mark. A write to a defined register also empties it.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // Request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]   s_address,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]   m_block_address,
    output logic [fbpa_pkg::STATUS_W-1:0] m_status,
    output logic [fbpa_pkg::COUNT_W-1:0]  m_used_count
);

    localparam int MEM_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW     = fbpa_pkg::COUNT_W;
    localparam int BW     = fbpa_pkg::BSIZE_W;
    localparam int AW     = fbpa_pkg::ADDR_W;
    localparam int SW     = fbpa_pkg::SPAN_W;
    localparam int OW     = fbpa_pkg::OFF_W;
    localparam logic [BW-1:0] MAX_BLOCKS_CMP = BW'(MAX_BLOCKS);
    localparam logic [CW-1:0] COUNT_CAP      = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] COUNT_DEFAULT  =
        (MAX_BLOCKS < 1024) ? CW'(MAX_BLOCKS) : fbpa_pkg::COUNT_RESET;
    localparam logic [fbpa_pkg::STEP_W-1:0] LAST_STEP =
        fbpa_pkg::STEP_W'(fbpa_pkg::DIV_STEPS - 1);

    fbpa_pkg::fsm_state_t state_reg, state_next;

    // Configuration registers
    logic [AW-1:0] base_reg, base_next;
    logic [BW-1:0] bsize_reg, bsize_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] span_reg;

    // Pool state
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] used_reg, used_next;

    // Working registers of the current request
    logic          pop_reg, pop_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] prod_reg, prod_next;
    logic [AW-1:0] off_reg, off_next;
    logic [OW-1:0] rem_reg, rem_next;
    logic [CW-1:0] quo_reg, quo_next;
    logic [fbpa_pkg::STEP_W-1:0] step_reg, step_next;
    logic          give_reg, give_next;
    logic [fbpa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic [AW-1:0]                 m_addr_reg, m_addr_next;
    logic [fbpa_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CW-1:0]                 m_used_reg, m_used_next;

    // Link memory port
    logic              mem_en, mem_we;
    logic [CW-1:0]     mem_idx, mem_wdata, mem_rdata;
    logic [MEM_AW+CW-1:0] mem_idx_ext;
    logic [MEM_AW-1:0] mem_addr;

    // Divider step
    logic [OW-1:0] div_shift;
    logic [OW:0]   div_diff;

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic [BW-1:0] wr_bsize;
    logic [CW-1:0] wr_count;

    assign mem_idx_ext = {{MEM_AW{1'b0}}, mem_idx};
    assign mem_addr    = mem_idx_ext[MEM_AW-1:0];

    fbpa_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign pready          = 1'b1;
    assign s_ready         = (state_reg == fbpa_pkg::FSM_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_block_address = m_addr_reg;
    assign m_status        = m_status_reg;
    assign m_used_count    = m_used_reg;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    assign div_shift = OW'({{(OW-BW){1'b0}}, bsize_reg} << step_reg);
    assign div_diff  = {1'b0, rem_reg} - {1'b0, div_shift};

    always_comb begin
        wr_bsize = pwdata[BW-1:0];
        if (wr_bsize < fbpa_pkg::BSIZE_MIN) begin
            wr_bsize = fbpa_pkg::BSIZE_MIN;
        end else if (wr_bsize > fbpa_pkg::BSIZE_MAX) begin
            wr_bsize = fbpa_pkg::BSIZE_MAX;
        end
        wr_count = pwdata[CW-1:0];
        if (wr_count == '0) begin
            wr_count = CW'(1);
        end else if ({{(BW-CW){1'b0}}, wr_count} > MAX_BLOCKS_CMP) begin
            wr_count = COUNT_CAP;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            fbpa_pkg::REG_BASE:  prdata = base_reg;
            fbpa_pkg::REG_BSIZE: prdata = {{(fbpa_pkg::PDATA_W-BW){1'b0}}, bsize_reg};
            fbpa_pkg::REG_COUNT: prdata = {{(fbpa_pkg::PDATA_W-CW){1'b0}}, count_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        bsize_next      = bsize_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        fresh_next      = fresh_reg;
        used_next       = used_reg;
        pop_next        = pop_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        give_next       = give_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        m_used_next     = m_used_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_idx         = head_reg;
        mem_wdata       = head_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fbpa_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    off_next = s_address - base_reg;
                    if (s_cmd == fbpa_pkg::CMD_ALLOC) begin
                        if (used_reg >= count_reg) begin
                            res_status_next = fbpa_pkg::STAT_EMPTY;
                            give_next       = 1'b0;
                            state_next      = fbpa_pkg::FSM_FINISH;
                        end else begin
                            res_status_next = fbpa_pkg::STAT_DONE;
                            give_next       = 1'b1;
                            idx_next        = head_reg;
                            used_next       = used_reg + CW'(1);
                            if (head_reg == fresh_reg) begin
                                // No released block on the list: take the fresh one.
                                fresh_next = fresh_reg + CW'(1);
                                head_next  = fresh_reg + CW'(1);
                                pop_next   = 1'b0;
                            end else begin
                                mem_en   = 1'b1;
                                mem_idx  = head_reg;
                                pop_next = 1'b1;
                            end
                            state_next = fbpa_pkg::FSM_ALLOC;
                        end
                    end else begin
                        state_next = fbpa_pkg::FSM_CHECK;
                    end
                end
            end
            fbpa_pkg::FSM_ALLOC: begin
                prod_next = SW'(idx_reg) * SW'(bsize_reg);
                if (pop_reg) begin
                    head_next = mem_rdata;
                end
                state_next = fbpa_pkg::FSM_FINISH;
            end
            fbpa_pkg::FSM_CHECK: begin
                if (off_reg >= {{(AW-SW){1'b0}}, span_reg} || used_reg == '0) begin
                    res_status_next = fbpa_pkg::STAT_REJECT;
                    give_next       = 1'b0;
                    state_next      = fbpa_pkg::FSM_FINISH;
                end else begin
                    rem_next   = off_reg[OW-1:0];
                    quo_next   = '0;
                    step_next  = LAST_STEP;
                    state_next = fbpa_pkg::FSM_DIVIDE;
                end
            end
            fbpa_pkg::FSM_DIVIDE: begin
                // Restoring division, most significant quotient bit first.
                if (!div_diff[OW]) begin
                    rem_next = div_diff[OW-1:0];
                end
                quo_next = {quo_reg[CW-2:0], ~div_diff[OW]};
                if (step_reg == '0) begin
                    state_next = fbpa_pkg::FSM_COMMIT;
                end else begin
                    step_next = step_reg - fbpa_pkg::STEP_W'(1);
                end
            end
            fbpa_pkg::FSM_COMMIT: begin
                give_next = 1'b0;
                if (rem_reg != '0) begin
                    res_status_next = fbpa_pkg::STAT_REJECT;
                end else begin
                    res_status_next = fbpa_pkg::STAT_DONE;
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_idx   = quo_reg;
                    mem_wdata = head_reg;
                    head_next = quo_reg;
                    used_next = used_reg - CW'(1);
                end
                state_next = fbpa_pkg::FSM_FINISH;
            end
            fbpa_pkg::FSM_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = give_reg ?
                        base_reg + {{(AW-SW){1'b0}}, prod_reg} : '0;
                    m_status_next = res_status_reg;
                    m_used_next   = used_reg;
                    state_next    = fbpa_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = fbpa_pkg::FSM_IDLE;
            end
        endcase

        // Any write to a defined register restarts the pool.
        if (cfg_wr) begin
            unique case (cfg_idx)
                fbpa_pkg::REG_BASE: begin
                    base_next  = pwdata;
                    head_next  = '0;
                    fresh_next = '0;
                    used_next  = '0;
                end
                fbpa_pkg::REG_BSIZE: begin
                    bsize_next = wr_bsize;
                    head_next  = '0;
                    fresh_next = '0;
                    used_next  = '0;
                end
                fbpa_pkg::REG_COUNT: begin
                    count_next = wr_count;
                    head_next  = '0;
                    fresh_next = '0;
                    used_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbpa_pkg::FSM_IDLE;
            base_reg    <= '0;
            bsize_reg   <= fbpa_pkg::BSIZE_MIN;
            count_reg   <= COUNT_DEFAULT;
            head_reg    <= '0;
            fresh_reg   <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            bsize_reg   <= bsize_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            fresh_reg   <= fresh_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg       <= SW'(bsize_reg) * SW'(count_reg);
        pop_reg        <= pop_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        off_reg        <= off_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        give_reg       <= give_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
        m_used_reg     <= m_used_next;
    end

endmodule

FILE: hw/rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule
